>>> rtl/ccm_pkg.sv
// Package for the contact cache key matcher.
// Field widths, command and status codes, and the stored entry type.
// No dependencies.
`default_nettype none

package ccm_pkg;

  localparam int KEY_W  = 50;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 10;
  localparam int CMD_W  = 2;
  localparam int QCNT_W = 2;
  localparam int STAT_W = 2;

  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 152;

  localparam logic [KEY_W-1:0] PAIR_MASK = ~KEY_W'(64'hFF);

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MATCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ORDER = 2'd2;

  localparam logic [QCNT_W-1:0] QCNT_MAX = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] tangent;
    logic [WORD_W-1:0] normal;
    logic [KEY_W-1:0]  key;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/contact_cache_key_matcher.sv
// Contact cache key matcher: sorted entry table with binary-search lookup.
// One search unit (address midpoint, key compare) is reused for every lookup.
// Depends on ccm_pkg.
//
//  channel  direction  tdata                       tuser
//  s_axis   in         load/query fields (216 b)   command (2 b)
//  m_axis   out        two match results (152 b)   status (2 b)
//
// A match runs up to four lookups (exact for each point, then pair prefix for each
// point not found): a binary search in S_BS_RD/S_BS_CMP, then S_CHK_RD/S_CHK_CMP
// (consumed pair entries skipped) and S_MARK; a skipped lookup stays in S_NEXT.
// S_DONE registers the result of every clear, load and match. Reset empties the
// table at once. A result waiting in the output register stalls the next item at
// its end; the input is not ready until that item is registered.
`default_nettype none

module contact_cache_key_matcher #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // load_key, load_normal_bits, load_tangent_bits, query_count,
  // query_key_first, query_key_second
  input  wire logic [ccm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // command
  input  wire logic [ccm_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // found_first, index_first, normal_first_bits, tangent_first_bits,
  // found_second, index_second, normal_second_bits, tangent_second_bits, zero pad
  output logic [ccm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // status
  output logic [ccm_pkg::STAT_W-1:0]           m_axis_tuser
);

  import ccm_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_BS_RD, S_BS_CMP, S_CHK_RD, S_CHK_CMP, S_MARK, S_DONE
  } state_t;

  state_t state;

  entry_t mem [CAPACITY];
  logic   mark_mem [CAPACITY];
  entry_t mem_q;
  logic   mark_q;

  logic [CW-1:0]     count;
  logic [KEY_W-1:0]  last_key;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     mid;
  logic [KEY_W-1:0]  target;
  logic [KEY_W-1:0]  qkey [2];
  logic [QCNT_W-1:0] qn;
  logic              pt;
  logic              pair_phase;
  logic              found [2];
  logic [AW-1:0]     pos [2];
  logic [WORD_W-1:0] nrm [2];
  logic [WORD_W-1:0] tan [2];
  logic [STAT_W-1:0] stat;

  logic [KEY_W-1:0]  in_load_key;
  logic [WORD_W-1:0] in_normal;
  logic [WORD_W-1:0] in_tangent;
  logic [QCNT_W-1:0] in_qcnt;
  logic [KEY_W-1:0]  in_qkey0;
  logic [KEY_W-1:0]  in_qkey1;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_c;
  logic          accept;
  logic          load_full;
  logic          load_order;
  logic          load_ok;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mark_we;
  logic [AW-1:0] mark_waddr;
  logic          mark_wdata;
  logic          out_free;

  assign in_load_key = s_axis_tdata[49:0];
  assign in_normal   = s_axis_tdata[81:50];
  assign in_tangent  = s_axis_tdata[113:82];
  assign in_qcnt     = s_axis_tdata[115:114];
  assign in_qkey0    = s_axis_tdata[165:116];
  assign in_qkey1    = s_axis_tdata[215:166];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign load_full  = (count >= CW'(CAPACITY));
  assign load_order = (count != '0) && (in_load_key <= last_key);
  assign load_ok    = accept && (s_axis_tuser == CMD_LOAD) && !load_full && !load_order;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_c   = mid_sum[CW:1];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = lo[AW-1:0];
    if (state == S_BS_RD) begin
      rd_en   = (lo < hi);
      rd_addr = mid_c[AW-1:0];
    end else if (state == S_CHK_RD) begin
      rd_en   = (lo < count);
    end
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = count[AW-1:0];
    mark_wdata = 1'b0;
    if (load_ok) begin
      mark_we = 1'b1;
    end else if ((state == S_MARK) && found[pt]) begin
      mark_we    = 1'b1;
      mark_waddr = pos[pt];
      mark_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[count[AW-1:0]] <= '{tangent: in_tangent, normal: in_normal, key: in_load_key};
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (rd_en) begin
      mark_q <= mark_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            found[0]   <= 1'b0;
            found[1]   <= 1'b0;
            pos[0]     <= '0;
            pos[1]     <= '0;
            nrm[0]     <= '0;
            nrm[1]     <= '0;
            tan[0]     <= '0;
            tan[1]     <= '0;
            stat       <= STAT_OK;
            pt         <= 1'b0;
            pair_phase <= 1'b0;
            qkey[0]    <= in_qkey0;
            qkey[1]    <= in_qkey1;
            qn         <= (in_qcnt > QCNT_MAX) ? QCNT_MAX : in_qcnt;
            state      <= S_DONE;
            case (s_axis_tuser)
              CMD_CLEAR: begin
                count <= '0;
              end
              CMD_LOAD: begin
                if (load_full) begin
                  stat <= STAT_FULL;
                end else if (load_order) begin
                  stat <= STAT_ORDER;
                end else begin
                  count    <= CW'(count + 1'b1);
                  last_key <= in_load_key;
                end
              end
              CMD_MATCH: begin
                state <= S_NEXT;
              end
              default: begin
              end
            endcase
          end
        end
        S_NEXT: begin
          if ((2'(pt) < qn) && (!pair_phase || !found[pt])) begin
            target <= pair_phase ? (qkey[pt] & PAIR_MASK) : qkey[pt];
            lo     <= '0;
            hi     <= count;
            state  <= S_BS_RD;
          end else if (!pt) begin
            pt <= 1'b1;
          end else if (!pair_phase) begin
            pt         <= 1'b0;
            pair_phase <= 1'b1;
          end else begin
            state <= S_DONE;
          end
        end
        S_BS_RD: begin
          mid   <= mid_c;
          state <= (lo < hi) ? S_BS_CMP : S_CHK_RD;
        end
        S_BS_CMP: begin
          if (mem_q.key < target) begin
            lo <= CW'(mid + 1'b1);
          end else begin
            hi <= mid;
          end
          state <= S_BS_RD;
        end
        S_CHK_RD: begin
          state <= (lo < count) ? S_CHK_CMP : S_MARK;
        end
        S_CHK_CMP: begin
          state <= S_MARK;
          if (!pair_phase) begin
            if (mem_q.key == target) begin
              found[pt] <= 1'b1;
              pos[pt]   <= lo[AW-1:0];
              nrm[pt]   <= mem_q.normal;
              tan[pt]   <= mem_q.tangent;
            end
          end else if ((mem_q.key & PAIR_MASK) == target) begin
            if (!mark_q) begin
              found[pt] <= 1'b1;
              pos[pt]   <= lo[AW-1:0];
              nrm[pt]   <= mem_q.normal;
              tan[pt]   <= mem_q.tangent;
            end else begin
              lo    <= CW'(lo + 1'b1);
              state <= S_CHK_RD;
            end
          end
        end
        S_MARK: begin
          state <= S_NEXT;
          if (!pt) begin
            pt <= 1'b1;
          end else if (!pair_phase) begin
            pt         <= 1'b0;
            pair_phase <= 1'b1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00,
                              tan[1], nrm[1], IDX_W'(pos[1]), found[1],
                              tan[0], nrm[0], IDX_W'(pos[0]), found[0]};
            m_axis_tuser  <= stat;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> bench/contact_cache_key_matcher_test.sv
// Self-checking bench for contact_cache_key_matcher: table loads, clears and
// two-point key matches checked against a local model of the sorted cache.
// Depends on ccm_pkg and contact_cache_key_matcher.
`timescale 1ns / 100ps

module contact_cache_key_matcher_test;
  import ccm_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3000;
  localparam int LONG_HOLD = 600;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  load_key;
    logic [WORD_W-1:0] normal;
    logic [WORD_W-1:0] tangent;
    logic [QCNT_W-1:0] qcnt;
    logic [KEY_W-1:0]  key_a;
    logic [KEY_W-1:0]  key_b;
    bit                drain_first;
    bit                calm;
  } cache_op_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [1:0]        pad;
    logic [WORD_W-1:0] tangent_second;
    logic [WORD_W-1:0] normal_second;
    logic [IDX_W-1:0]  index_second;
    logic              found_second;
    logic [WORD_W-1:0] tangent_first;
    logic [WORD_W-1:0] normal_first;
    logic [IDX_W-1:0]  index_first;
    logic              found_first;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0] m_axis_tuser;

  contact_cache_key_matcher #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  cache_op_t pending_ops[$];
  cache_result_t expected_results[$];
  int errors = 0;

  // cache model
  logic [KEY_W-1:0]  model_keys[TABLE_DEPTH];
  logic [WORD_W-1:0] model_normal[TABLE_DEPTH];
  logic [WORD_W-1:0] model_tangent[TABLE_DEPTH];
  bit [TABLE_DEPTH-1:0] model_consumed = '0;
  int model_count = 0;

  function automatic int first_not_below(logic [KEY_W-1:0] target);
    int lo, hi, mid;
    lo = 0;
    hi = model_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (model_keys[mid] < target) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic int exact_slot(logic [KEY_W-1:0] key);
    int p;
    p = first_not_below(key);
    if (p < model_count && model_keys[p] == key) return p;
    return -1;
  endfunction

  function automatic int free_pair_slot(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] prefix;
    int p;
    prefix = key & PAIR_MASK;
    p = first_not_below(prefix);
    while (p < model_count && (model_keys[p] & PAIR_MASK) == prefix) begin
      if (!model_consumed[p]) return p;
      p++;
    end
    return -1;
  endfunction

  function automatic cache_result_t apply_cache_op(cache_op_t op);
    cache_result_t r;
    int n;
    int pos[2];
    bit hit[2];
    logic [KEY_W-1:0] qk[2];
    r = '0;
    r.status = STAT_OK;
    pos[0] = -1;
    pos[1] = -1;
    hit[0] = 0;
    hit[1] = 0;
    case (op.cmd)
      CMD_CLEAR: begin
        model_count = 0;
        model_consumed = '0;
      end
      CMD_LOAD: begin
        if (model_count >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else if (model_count > 0 && op.load_key <= model_keys[model_count-1]) begin
          r.status = STAT_ORDER;
        end else begin
          model_keys[model_count] = op.load_key;
          model_normal[model_count] = op.normal;
          model_tangent[model_count] = op.tangent;
          model_consumed[model_count] = 0;
          model_count++;
        end
      end
      CMD_MATCH: begin
        n = (op.qcnt > QCNT_MAX) ? int'(QCNT_MAX) : int'(op.qcnt);
        qk[0] = op.key_a;
        qk[1] = op.key_b;
        for (int i = 0; i < n; i++) begin
          pos[i] = exact_slot(qk[i]);
          hit[i] = pos[i] >= 0;
          if (hit[i]) model_consumed[pos[i]] = 1;
        end
        for (int i = 0; i < n; i++) begin
          if (!hit[i]) begin
            pos[i] = free_pair_slot(qk[i]);
            hit[i] = pos[i] >= 0;
            if (hit[i]) model_consumed[pos[i]] = 1;
          end
        end
        if (hit[0]) begin
          r.found_first = 1'b1;
          r.index_first = IDX_W'(pos[0]);
          r.normal_first = model_normal[pos[0]];
          r.tangent_first = model_tangent[pos[0]];
        end
        if (hit[1]) begin
          r.found_second = 1'b1;
          r.index_second = IDX_W'(pos[1]);
          r.normal_second = model_normal[pos[1]];
          r.tangent_second = model_tangent[pos[1]];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // stimulus generation
  logic [KEY_W-1:0] gen_keys[$];
  logic [KEY_W-1:0] gen_cursor;
  bit gen_calm = 0;
  bit gen_drain = 0;

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'({$urandom(), $urandom()});
  endfunction

  function automatic cache_op_t random_op(logic [CMD_W-1:0] cmd);
    cache_op_t op;
    op.cmd = cmd;
    op.load_key = rand_key();
    op.normal = $urandom();
    op.tangent = $urandom();
    op.qcnt = QCNT_W'($urandom_range(0, 3));
    op.key_a = rand_key();
    op.key_b = rand_key();
    op.drain_first = 0;
    op.calm = 0;
    return op;
  endfunction

  task automatic queue_op(cache_op_t op);
    op.calm = gen_calm;
    op.drain_first = gen_drain;
    gen_drain = 0;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic add_load(logic [KEY_W-1:0] key);
    cache_op_t op;
    op = random_op(CMD_LOAD);
    op.load_key = key;
    queue_op(op);
  endtask

  task automatic add_match(logic [QCNT_W-1:0] qcnt, logic [KEY_W-1:0] ka,
                           logic [KEY_W-1:0] kb);
    cache_op_t op;
    op = random_op(CMD_MATCH);
    op.qcnt = qcnt;
    op.key_a = ka;
    op.key_b = kb;
    queue_op(op);
  endtask

  task automatic add_clear();
    queue_op(random_op(CMD_CLEAR));
  endtask

  task automatic start_table();
    add_clear();
    gen_keys.delete();
    gen_cursor = rand_key();
    if (gen_cursor > KEY_MAX - (KEY_W'(1) << 20)) gen_cursor = gen_cursor - (KEY_W'(1) << 20);
  endtask

  task automatic add_next_load();
    logic [KEY_W-1:0] k;
    int r, mis;
    r = $urandom_range(0, 99);
    if (gen_keys.size() > 0 && r < 10) begin
      mis = $urandom_range(0, 40);
      k = gen_keys[$];
      if (k >= KEY_W'(mis)) k = k - KEY_W'(mis);
      add_load(k);
    end else begin
      if (r < 30)
        gen_cursor = (gen_cursor & PAIR_MASK) + KEY_W'(256 * $urandom_range(1, 3))
                     + KEY_W'($urandom_range(0, 255));
      else
        gen_cursor = gen_cursor + KEY_W'($urandom_range(1, 3));
      add_load(gen_cursor);
      if (gen_keys.size() < TABLE_DEPTH) gen_keys.insert(gen_keys.size(), gen_cursor);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_query_key();
    int r;
    if (gen_keys.size() == 0) return rand_key();
    r = $urandom_range(0, 99);
    if (r < 40) return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    if (r < 75)
      return (gen_keys[$urandom_range(0, gen_keys.size() - 1)] & PAIR_MASK)
             | KEY_W'($urandom_range(0, 255));
    return rand_key();
  endfunction

  task automatic add_random_match();
    logic [KEY_W-1:0] ka, kb;
    logic [QCNT_W-1:0] qcnt;
    int r;
    r = $urandom_range(0, 99);
    qcnt = (r < 70) ? QCNT_W'(2) : (r < 85) ? QCNT_W'(1) : (r < 93) ? QCNT_W'(3) : QCNT_W'(0);
    ka = pick_query_key();
    kb = ($urandom_range(0, 9) == 0) ? ka : pick_query_key();
    add_match(qcnt, ka, kb);
  endtask

  task automatic add_session(int n_ops);
    int r;
    start_table();
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      if (r < 55) add_next_load();
      else if (r < 97) add_random_match();
      else queue_op(random_op(CMD_UNUSED));
    end
  endtask

  task automatic add_directed();
    cache_op_t op;
    add_clear();
    add_match(2'd2, KEY_W'(50'h107), KEY_W'(50'h0));
    op = random_op(CMD_LOAD);
    op.load_key = '0;
    op.normal = '0;
    op.tangent = '0;
    queue_op(op);
    op = random_op(CMD_LOAD);
    op.load_key = KEY_W'(50'h105);
    op.normal = '1;
    op.tangent = '1;
    queue_op(op);
    add_load(KEY_W'(50'h107));
    add_load(KEY_W'(50'h107));
    add_load(KEY_W'(50'h50));
    add_load(KEY_MAX);
    add_match(2'd1, KEY_W'(50'h107), rand_key());
    add_match(2'd2, KEY_W'(50'h107), KEY_W'(50'h107));
    add_match(2'd2, KEY_W'(50'h1AA), KEY_W'(50'h1BB));
    add_match(2'd3, KEY_MAX, KEY_W'(50'h0));
    add_match(2'd0, KEY_MAX, KEY_W'(50'h0));
    queue_op(random_op(CMD_UNUSED));
    gen_drain = 1;
    add_clear();
    add_match(2'd1, KEY_W'(50'h107), rand_key());
    add_load(KEY_W'(50'h105));
    add_match(2'd2, KEY_W'(50'h1FF), KEY_W'(50'h105));
  endtask

  // source side
  cache_op_t offered;
  bit src_busy = 0;
  int src_gap = 0;
  bit calm_phase = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.insert(expected_results.size(), apply_cache_op(offered));
        src_busy = 0;
      end
      if (!src_busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain_first && expected_results.size() > 0)) begin
          offered = pending_ops.pop_front();
          src_busy = 1;
          calm_phase <= offered.calm;
          s_axis_tdata <= {offered.key_b, offered.key_a, offered.qcnt, offered.tangent,
                           offered.normal, offered.load_key};
          s_axis_tuser <= offered.cmd;
          if (!offered.calm && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 8);
        end
        s_axis_tvalid <= src_busy;
      end
    end
  end

  // sink side
  int sink_hold = 0;
  int results_seen = 0;
  bit long_hold_done = 0;

  function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
      return 0;
    end
    return 1;
  endfunction

  always @(posedge clk) begin : sink
    cache_result_t got, want;
    bit ok;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $realtime, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          ok = 1;
          ok &= field_ok("status", 64'(want.status), 64'(got.status));
          ok &= field_ok("pad", 64'(want.pad), 64'(got.pad));
          ok &= field_ok("found_first", 64'(want.found_first), 64'(got.found_first));
          ok &= field_ok("index_first", 64'(want.index_first), 64'(got.index_first));
          ok &= field_ok("normal_first", 64'(want.normal_first), 64'(got.normal_first));
          ok &= field_ok("tangent_first", 64'(want.tangent_first), 64'(got.tangent_first));
          ok &= field_ok("found_second", 64'(want.found_second), 64'(got.found_second));
          ok &= field_ok("index_second", 64'(want.index_second), 64'(got.index_second));
          ok &= field_ok("normal_second", 64'(want.normal_second), 64'(got.normal_second));
          ok &= field_ok("tangent_second", 64'(want.tangent_second),
                         64'(got.tangent_second));
          if (!ok) errors++;
        end
      end
      // hold off long enough to back the block up
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1;
        sink_hold = LONG_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(1, 8) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    add_directed();
    for (int s = 0; s < 12; s++) begin
      gen_drain = (s % 2 == 0);
      add_session($urandom_range(30, 50));
    end
    gen_drain = 1;
    start_table();
    while (gen_keys.size() < TABLE_DEPTH) begin
      if ($urandom_range(0, 99) < 8) add_random_match();
      else add_next_load();
    end
    repeat (3) add_next_load();
    repeat (40) add_random_match();
    while (pending_ops.size() < 1770) add_session($urandom_range(30, 50));
    gen_calm = 1;
    while (pending_ops.size() < 1970) add_session($urandom_range(30, 50));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
